/* rtl/serial_datetime_line_parser_unit_assert.svh */
// Assertion macros used by the checker file of the date/time line parser.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef SERIAL_DATETIME_LINE_PARSER_UNIT_ASSERT_SVH
`define SERIAL_DATETIME_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define SDLP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define SDLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked at every edge, reset included.
`define SDLP_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/sdlp_pkg.sv */
// ----------------------------------------------------------------------------
// sdlp_pkg
// Constants and helper functions of the serial date/time line parser.
// ----------------------------------------------------------------------------
package sdlp_pkg;

    // Number of digits in a complete line (YYMMDDWHHMMSS).
    localparam int unsigned LINE_DIGITS = 13;

    // Width of the digit counter; it must hold LINE_DIGITS itself.
    localparam int unsigned COUNT_W = 4;

    // Characters of interest.
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Field limits.
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MAX    = 7'd31;
    localparam logic [3:0] WEEKDAY_MAX = 4'd7;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINSEC_MAX = 7'd59;

    // Value of a two-digit decimal number: tens * 10 + units.
    function automatic logic [6:0] two_digits(logic [3:0] tens, logic [3:0] units);
        logic [6:0] t7;
        t7 = {3'b000, tens};
        return (t7 << 3) + (t7 << 1) + {3'b000, units};
    endfunction

endpackage

/* rtl/sdlp_byte_if.sv */
// ----------------------------------------------------------------------------
// sdlp_byte_if
// Valid/ready channel carrying one received character per item.
// ----------------------------------------------------------------------------
interface sdlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/sdlp_result_if.sv */
// ----------------------------------------------------------------------------
// sdlp_result_if
// Valid/ready channel carrying one parsed date/time result per item.
// ----------------------------------------------------------------------------
interface sdlp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [3:0] weekday;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;

    modport source (output valid, output status, output year, output month,
                    output day, output weekday, output hour, output minute,
                    output second, input ready);
    modport sink   (input valid, input status, input year, input month,
                    input day, input weekday, input hour, input minute,
                    input second, output ready);
endinterface

/* rtl/serial_datetime_line_parser_unit.sv */
// ----------------------------------------------------------------------------
// serial_datetime_line_parser_unit
// Collects decimal digits of a text line and reports a parsed date and time.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received character per item. Digits are collected, up to
//   13 per line; LF or CR ends a line. Other characters are ignored.
//   res carries one item per line end that follows at least one digit:
//   status 0 for a valid YYMMDDWHHMMSS line, 1 for fewer than 13 digits
//   (all fields zero), or 2 when a field is out of range (fields as parsed).
//   A line end passes from the input register into the result register.
//   Throughput: one character per cycle, unless a line end is held back.
//   Each character passes through an input register. From there a digit
//   updates the digit store, and a line end loads the decoded fields into
//   the result register.
//   When res stalls, characters that yield no result keep flowing; a line
//   end waits in the input register until the result register is free.
//   Reset clears the digit count and both valid flags; the digit store is
//   only read after 13 fresh writes and needs no reset.
// ----------------------------------------------------------------------------
module serial_datetime_line_parser_unit
    import sdlp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sdlp_byte_if.sink     rx,
    sdlp_result_if.source res
);

    // Input register.
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;

    // Line state.
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         store_reg [LINE_DIGITS];

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic [6:0] year_reg, year_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] day_reg, day_next;
    logic [3:0] weekday_reg, weekday_next;
    logic [6:0] hour_reg, hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] second_reg, second_next;

    logic is_eol, is_digit, count_full, produce, advance, rx_accept, load;
    logic [6:0] yr, mo, dy, hr, mi, se;
    logic [3:0] wd;
    logic       fields_ok;

    // Character classification.
    assign is_eol     = (in_byte_reg == CHAR_LF) || (in_byte_reg == CHAR_CR);
    assign is_digit   = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign count_full = (count_reg == COUNT_W'(LINE_DIGITS));

    // Handshake: a held item moves on unless it needs a busy result register.
    assign produce   = in_valid_reg && is_eol && (count_reg != '0);
    assign advance   = in_valid_reg && (!produce || !out_valid_reg || res.ready);
    assign rx.ready  = !in_valid_reg || advance;
    assign rx_accept = rx.valid && rx.ready;
    assign load      = advance && produce;

    // Field decoding from the fixed digit positions.
    assign yr = two_digits(store_reg[0], store_reg[1]);
    assign mo = two_digits(store_reg[2], store_reg[3]);
    assign dy = two_digits(store_reg[4], store_reg[5]);
    assign wd = store_reg[6];
    assign hr = two_digits(store_reg[7], store_reg[8]);
    assign mi = two_digits(store_reg[9], store_reg[10]);
    assign se = two_digits(store_reg[11], store_reg[12]);

    // The year can never exceed 99, so it takes no check.
    assign fields_ok = (mo != '0) && (mo <= MONTH_MAX)
                    && (dy != '0) && (dy <= DAY_MAX)
                    && (wd != '0) && (wd <= WEEKDAY_MAX)
                    && (hr <= HOUR_MAX)
                    && (mi <= MINSEC_MAX)
                    && (se <= MINSEC_MAX);

    // Next values of the control state.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        count_next = count_reg;
        if (advance)
        begin
            if (is_eol)
            begin
                count_next = '0;
            end
            else if (is_digit && !count_full)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Result payload for the line that ends now.
    always_comb
    begin
        if (count_full)
        begin
            status_next  = fields_ok ? ST_OK : ST_RANGE;
            year_next    = yr;
            month_next   = mo;
            day_next     = dy;
            weekday_next = wd;
            hour_next    = hr;
            minute_next  = mi;
            second_next  = se;
        end
        else
        begin
            status_next  = ST_LEN;
            year_next    = '0;
            month_next   = '0;
            day_next     = '0;
            weekday_next = '0;
            hour_next    = '0;
            minute_next  = '0;
            second_next  = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input character, digit store and result fields.
    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && is_digit && !count_full)
        begin
            store_reg[count_reg] <= in_byte_reg[3:0];
        end
        if (load)
        begin
            status_reg  <= status_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            weekday_reg <= weekday_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
        end
    end

    // Output channel.
    assign res.valid   = out_valid_reg;
    assign res.status  = status_reg;
    assign res.year    = year_reg;
    assign res.month   = month_reg;
    assign res.day     = day_reg;
    assign res.weekday = weekday_reg;
    assign res.hour    = hour_reg;
    assign res.minute  = minute_reg;
    assign res.second  = second_reg;

endmodule

/* rtl/sdlp_checker.sv */
// ----------------------------------------------------------------------------
// sdlp_checker
// Port-level checks of the serial date/time line parser.
// ----------------------------------------------------------------------------
`include "serial_datetime_line_parser_unit_assert.svh"

module sdlp_checker
    import sdlp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] status,
    input logic [6:0] year,
    input logic [6:0] month,
    input logic [6:0] day,
    input logic [3:0] weekday,
    input logic [6:0] hour,
    input logic [6:0] minute,
    input logic [6:0] second
);

    // No result is offered while reset is applied.
    `SDLP_ASSERT_ALWAYS(a_reset_idle, !rst_n, !res_valid, "result valid during reset")

    // A length error carries all-zero fields.
    `SDLP_ASSERT_IMPL(a_len_zero, res_valid && (status == ST_LEN), (year == '0) && (month == '0) && (day == '0) && (weekday == '0) && (hour == '0) && (minute == '0) && (second == '0), "length error with nonzero fields")

    // An accepted date has every field in range.
    `SDLP_ASSERT_IMPL(a_ok_range, res_valid && (status == ST_OK), (month != '0) && (month <= MONTH_MAX) && (day != '0) && (day <= DAY_MAX) && (weekday != '0) && (weekday <= WEEKDAY_MAX) && (hour <= HOUR_MAX) && (minute <= MINSEC_MAX) && (second <= MINSEC_MAX), "valid status with field out of range")

    // A stalled result stays valid with status, month and second unchanged.
    `SDLP_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(month) && $stable(second), "stalled result changed")

endmodule

bind serial_datetime_line_parser_unit sdlp_checker u_sdlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .status    (res.status),
    .year      (res.year),
    .month     (res.month),
    .day       (res.day),
    .weekday   (res.weekday),
    .hour      (res.hour),
    .minute    (res.minute),
    .second    (res.second)
);
